>>> design/smstat_pkg.sv
// Shared types and constants for the sparse matrix statistics core.
// Depends on nothing; imported by the front end, the accumulator and the top level.
`default_nettype none

package smstat_pkg;

    localparam int VALUE_W  = 32;
    localparam int MAG_W    = 32;
    localparam int ABS_W    = 31;
    localparam int SQ_W     = 63;
    localparam int OFF_W    = 40;
    localparam int NZ_OUT_W = 9;
    localparam int ROWS_OUT_W = 17;

    localparam logic [ABS_W-1:0] ABS_SAT = {ABS_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_SAT  = {SQ_W{1'b1}};
    localparam logic [OFF_W-1:0] OFF_SAT = {OFF_W{1'b1}};
    localparam logic signed [VALUE_W-1:0] VALUE_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_NEG_MAX = {1'b1, {(VALUE_W-1){1'b0}}};

    // One nonzero after magnitude and square have been worked out.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [MAG_W-1:0]          mag;
        logic [SQ_W-1:0]           square;
        logic                      is_diag;
        logic                      has_entry;
        logic                      row_last;
        logic                      matrix_last;
    } item_t;

endpackage

`default_nettype wire

>>> design/smstat_front.sv
// Front end: input register with magnitude and diagonal check, then the squaring stage.
// Depends on smstat_pkg.
`default_nettype none

module smstat_front
    import smstat_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [15:0]               row_index,
    input  wire logic [15:0]               col_index,
    input  wire logic signed [VALUE_W-1:0] entry_value,
    input  wire logic                      has_entry,
    input  wire logic                      row_last,
    input  wire logic                      matrix_last,
    input  wire logic                      entry_valid,
    output logic                           entry_ready,
    output item_t                          item,
    output logic                           item_valid,
    input  wire logic                      item_ready
);

    logic                      a_valid_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    logic [MAG_W-1:0]          a_mag_reg;
    logic                      a_diag_reg;
    logic                      a_has_reg;
    logic                      a_rlast_reg;
    logic                      a_mlast_reg;
    logic                      b_valid_reg;
    item_t                     b_item_reg;
    logic [MAG_W-1:0]          in_mag;
    logic [2*MAG_W-1:0]        a_product;
    logic                      b_free;
    logic                      a_free;

    // The exact magnitude of the most negative value is 2^31, which fits 32 unsigned bits.
    assign in_mag    = entry_value[VALUE_W-1] ? (~entry_value + 1'b1) : entry_value;
    assign a_product = a_mag_reg * a_mag_reg;

    assign b_free      = !b_valid_reg || item_ready;
    assign a_free      = !a_valid_reg || b_free;
    assign entry_ready = a_free;
    assign item_valid  = b_valid_reg;
    assign item        = b_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= entry_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && entry_valid)
        begin
            a_value_reg <= entry_value;
            a_mag_reg   <= in_mag;
            a_diag_reg  <= (row_index == col_index);
            a_has_reg   <= has_entry;
            a_rlast_reg <= row_last;
            a_mlast_reg <= matrix_last;
        end
        if (b_free && a_valid_reg)
        begin
            b_item_reg.value       <= a_value_reg;
            b_item_reg.mag         <= a_mag_reg;
            // The square is at most 2^62, so the top product bit is always zero.
            b_item_reg.square      <= a_product[SQ_W-1:0];
            b_item_reg.is_diag     <= a_diag_reg;
            b_item_reg.has_entry   <= a_has_reg;
            b_item_reg.row_last    <= a_rlast_reg;
            b_item_reg.matrix_last <= a_mlast_reg;
        end
    end

endmodule

`default_nettype wire

>>> design/smstat_accum.sv
// Running statistics, per-row dominance test and the result register.
// Depends on smstat_pkg.
`default_nettype none

module smstat_accum
    import smstat_pkg::*;
#(
    parameter int MAX_ROWS        = 65536,
    parameter int MAX_ROW_ENTRIES = 256
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire item_t                     item,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    output logic signed [VALUE_W-1:0]      min_value,
    output logic signed [VALUE_W-1:0]      max_value,
    output logic [ABS_W-1:0]               min_abs_value,
    output logic [ABS_W-1:0]               max_abs_value,
    output logic [SQ_W-1:0]                sum_of_squares,
    output logic [NZ_OUT_W-1:0]            min_row_nonzeros,
    output logic [NZ_OUT_W-1:0]            max_row_nonzeros,
    output logic [ROWS_OUT_W-1:0]          dominant_rows,
    output logic [ROWS_OUT_W-1:0]          weak_dominant_rows,
    output logic                           stats_valid,
    input  wire logic                      stats_ready
);

    localparam int CNT_W  = $clog2(MAX_ROW_ENTRIES + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam logic [CNT_W-1:0]  ENT_MAX  = CNT_W'(MAX_ROW_ENTRIES);
    localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_ROWS);

    logic signed [VALUE_W-1:0] run_min_reg, run_max_reg;
    logic [ABS_W-1:0]          run_min_abs_reg, run_max_abs_reg;
    logic [SQ_W-1:0]           square_sum_reg;
    logic [MAG_W-1:0]          diag_mag_reg;
    logic [OFF_W-1:0]          offdiag_reg;
    logic [CNT_W-1:0]          entry_cnt_reg, fewest_reg, most_reg;
    logic [ROWS_W-1:0]         strict_reg, weak_reg;
    logic                      stats_valid_reg;

    logic signed [VALUE_W-1:0] run_min_next, run_max_next;
    logic [ABS_W-1:0]          run_min_abs_next, run_max_abs_next;
    logic [SQ_W-1:0]           square_sum_next;
    logic [MAG_W-1:0]          diag_mag_next;
    logic [OFF_W-1:0]          offdiag_next;
    logic [CNT_W-1:0]          entry_cnt_next, fewest_next, most_next;
    logic [ROWS_W-1:0]         strict_next, weak_next;

    logic [ABS_W-1:0]          mag_sat;
    logic [SQ_W:0]             sq_wide;
    logic [OFF_W:0]            off_wide;
    logic                      closing;
    logic                      diag_gt, diag_eq;
    logic                      go;

    // A result-bearing item may only move on when the result register is free.
    assign item_ready = !item.matrix_last || !stats_valid_reg || stats_ready;
    assign go         = item_valid && item_ready;
    assign stats_valid = stats_valid_reg;

    always_comb
    begin
        mag_sat  = item.mag[MAG_W-1] ? ABS_SAT : item.mag[ABS_W-1:0];
        sq_wide  = {1'b0, square_sum_reg} + {1'b0, item.square};
        off_wide = {1'b0, offdiag_reg} + (OFF_W+1)'(item.mag);
        closing  = item.row_last || item.matrix_last;

        run_min_next     = run_min_reg;
        run_max_next     = run_max_reg;
        run_min_abs_next = run_min_abs_reg;
        run_max_abs_next = run_max_abs_reg;
        square_sum_next  = square_sum_reg;
        diag_mag_next    = diag_mag_reg;
        offdiag_next     = offdiag_reg;
        entry_cnt_next   = entry_cnt_reg;

        if (item.has_entry)
        begin
            if (item.value < run_min_reg)
                run_min_next = item.value;
            if (item.value > run_max_reg)
                run_max_next = item.value;
            if (mag_sat < run_min_abs_reg)
                run_min_abs_next = mag_sat;
            if (mag_sat > run_max_abs_reg)
                run_max_abs_next = mag_sat;
            square_sum_next = sq_wide[SQ_W] ? SQ_SAT : sq_wide[SQ_W-1:0];
            if (item.is_diag)
                diag_mag_next = item.mag;
            else
                offdiag_next = off_wide[OFF_W] ? OFF_SAT : off_wide[OFF_W-1:0];
            if (entry_cnt_reg < ENT_MAX)
                entry_cnt_next = entry_cnt_reg + 1'b1;
        end

        // Row close works on the row totals that already include this beat.
        diag_gt = OFF_W'(diag_mag_next) > offdiag_next;
        diag_eq = OFF_W'(diag_mag_next) == offdiag_next;

        fewest_next = fewest_reg;
        most_next   = most_reg;
        strict_next = strict_reg;
        weak_next   = weak_reg;
        if (closing)
        begin
            if (entry_cnt_next < fewest_reg)
                fewest_next = entry_cnt_next;
            if (entry_cnt_next > most_reg)
                most_next = entry_cnt_next;
            if (diag_gt && strict_reg < ROWS_MAX)
                strict_next = strict_reg + 1'b1;
            if (diag_eq && weak_reg < ROWS_MAX)
                weak_next = weak_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg     <= VALUE_POS_MAX;
            run_max_reg     <= VALUE_NEG_MAX;
            run_min_abs_reg <= ABS_SAT;
            run_max_abs_reg <= '0;
            square_sum_reg  <= '0;
            diag_mag_reg    <= '0;
            offdiag_reg     <= '0;
            entry_cnt_reg   <= '0;
            fewest_reg      <= ENT_MAX;
            most_reg        <= '0;
            strict_reg      <= '0;
            weak_reg        <= '0;
            stats_valid_reg <= 1'b0;
        end
        else
        begin
            if (go && item.matrix_last)
                stats_valid_reg <= 1'b1;
            else if (stats_ready)
                stats_valid_reg <= 1'b0;
            if (go)
            begin
                if (item.matrix_last)
                begin
                    // The result is captured and every statistic starts over.
                    run_min_reg     <= VALUE_POS_MAX;
                    run_max_reg     <= VALUE_NEG_MAX;
                    run_min_abs_reg <= ABS_SAT;
                    run_max_abs_reg <= '0;
                    square_sum_reg  <= '0;
                    fewest_reg      <= ENT_MAX;
                    most_reg        <= '0;
                    strict_reg      <= '0;
                    weak_reg        <= '0;
                end
                else
                begin
                    run_min_reg     <= run_min_next;
                    run_max_reg     <= run_max_next;
                    run_min_abs_reg <= run_min_abs_next;
                    run_max_abs_reg <= run_max_abs_next;
                    square_sum_reg  <= square_sum_next;
                    fewest_reg      <= fewest_next;
                    most_reg        <= most_next;
                    strict_reg      <= strict_next;
                    weak_reg        <= weak_next;
                end
                if (closing)
                begin
                    diag_mag_reg  <= '0;
                    offdiag_reg   <= '0;
                    entry_cnt_reg <= '0;
                end
                else
                begin
                    diag_mag_reg  <= diag_mag_next;
                    offdiag_reg   <= offdiag_next;
                    entry_cnt_reg <= entry_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && item.matrix_last)
        begin
            min_value          <= run_min_next;
            max_value          <= run_max_next;
            min_abs_value      <= run_min_abs_next;
            max_abs_value      <= run_max_abs_next;
            sum_of_squares     <= square_sum_next;
            min_row_nonzeros   <= NZ_OUT_W'(fewest_next);
            max_row_nonzeros   <= NZ_OUT_W'(most_next);
            dominant_rows      <= ROWS_OUT_W'(strict_next);
            weak_dominant_rows <= ROWS_OUT_W'(weak_next);
        end
    end

endmodule

`default_nettype wire

>>> design/sparse_matrix_statistics_core.sv
// Top level of the sparse matrix statistics core: front end plus accumulator.
// Depends on smstat_pkg, smstat_front and smstat_accum.
//
//   Channel  Handshake                  Beat contents
//   entry    entry_valid / entry_ready  row_index, col_index, entry_value, has_entry,
//                                       row_last, matrix_last
//   stats    stats_valid / stats_ready  min/max value, min/max abs, sum_of_squares,
//                                       row nonzero range, dominance counts
//
// One beat per cycle while entry_ready is high; the squaring multiplier has its own stage.
// A result is registered after the matrix_last beat passes the input and squaring registers.
// Reset clears all statistics to their start values; no clearing pass is needed.
// While a result waits, entry beats keep flowing; only a second matrix end stalls behind it.
`default_nettype none

module sparse_matrix_statistics_core
    import smstat_pkg::*;
#(
    parameter int MAX_ROWS        = 65536,
    parameter int MAX_ROW_ENTRIES = 256
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [15:0]               row_index,
    input  wire logic [15:0]               col_index,
    input  wire logic signed [VALUE_W-1:0] entry_value,
    input  wire logic                      has_entry,
    input  wire logic                      row_last,
    input  wire logic                      matrix_last,
    input  wire logic                      entry_valid,
    output logic                           entry_ready,
    output logic signed [VALUE_W-1:0]      min_value,
    output logic signed [VALUE_W-1:0]      max_value,
    output logic [ABS_W-1:0]               min_abs_value,
    output logic [ABS_W-1:0]               max_abs_value,
    output logic [SQ_W-1:0]                sum_of_squares,
    output logic [NZ_OUT_W-1:0]            min_row_nonzeros,
    output logic [NZ_OUT_W-1:0]            max_row_nonzeros,
    output logic [ROWS_OUT_W-1:0]          dominant_rows,
    output logic [ROWS_OUT_W-1:0]          weak_dominant_rows,
    output logic                           stats_valid,
    input  wire logic                      stats_ready
);

    item_t item;
    logic  item_valid;
    logic  item_ready;

    smstat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .has_entry   (has_entry),
        .row_last    (row_last),
        .matrix_last (matrix_last),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .item        (item),
        .item_valid  (item_valid),
        .item_ready  (item_ready)
    );

    smstat_accum #(
        .MAX_ROWS        (MAX_ROWS),
        .MAX_ROW_ENTRIES (MAX_ROW_ENTRIES)
    ) u_accum (
        .clk                (clk),
        .rst_n              (rst_n),
        .item               (item),
        .item_valid         (item_valid),
        .item_ready         (item_ready),
        .min_value          (min_value),
        .max_value          (max_value),
        .min_abs_value      (min_abs_value),
        .max_abs_value      (max_abs_value),
        .sum_of_squares     (sum_of_squares),
        .min_row_nonzeros   (min_row_nonzeros),
        .max_row_nonzeros   (max_row_nonzeros),
        .dominant_rows      (dominant_rows),
        .weak_dominant_rows (weak_dominant_rows),
        .stats_valid        (stats_valid),
        .stats_ready        (stats_ready)
    );

endmodule

`default_nettype wire

>>> design/smstat_checker.sv
// Port-level checks for the sparse matrix statistics core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module smstat_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic signed [31:0] min_value,
    input wire logic signed [31:0] max_value,
    input wire logic [30:0]        min_abs_value,
    input wire logic [30:0]        max_abs_value,
    input wire logic [62:0]        sum_of_squares,
    input wire logic               stats_valid,
    input wire logic               stats_ready
);

    // A stalled result beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid && !stats_ready |=> stats_valid && $stable(min_value)
            && $stable(max_value) && $stable(sum_of_squares))
        else $error("stalled result beat changed");

    // Once any entry was seen, the magnitude range is ordered, and so is the value range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid && min_abs_value <= max_abs_value |-> min_value <= max_value)
        else $error("value range inverted although entries were seen");

    // All entries zero means a zero sum of squares.
    a_zero_sq: assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid && max_abs_value == 31'd0 && min_abs_value == 31'd0
            |-> sum_of_squares == 63'd0)
        else $error("nonzero sum of squares for all-zero entries");

    // With no negative entry, the smallest magnitude is the smallest value.
    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid && min_abs_value <= max_abs_value && !min_value[31]
            |-> min_abs_value == min_value[30:0])
        else $error("smallest magnitude disagrees with smallest value");

endmodule

bind sparse_matrix_statistics_core smstat_checker u_smstat_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_value      (min_value),
    .max_value      (max_value),
    .min_abs_value  (min_abs_value),
    .max_abs_value  (max_abs_value),
    .sum_of_squares (sum_of_squares),
    .stats_valid    (stats_valid),
    .stats_ready    (stats_ready)
);

`default_nettype wire

>>> tb/sparse_matrix_statistics_core_tb.sv
// Self-checking testbench for the sparse matrix statistics core.
// Streams directed and random matrices, predicts each statistics beat and compares it.
// Depends on smstat_pkg and sparse_matrix_statistics_core.
`timescale 1ns / 100ps

module sparse_matrix_statistics_core_tb
    import smstat_pkg::*;
();

    localparam int MAX_ROWS        = 65536;
    localparam int MAX_ROW_ENTRIES = 256;
    localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic [ABS_W-1:0]          min_abs_value;
        logic [ABS_W-1:0]          max_abs_value;
        logic [SQ_W-1:0]           sum_of_squares;
        logic [NZ_OUT_W-1:0]       min_row_nonzeros;
        logic [NZ_OUT_W-1:0]       max_row_nonzeros;
        logic [ROWS_OUT_W-1:0]     dominant_rows;
        logic [ROWS_OUT_W-1:0]     weak_dominant_rows;
    } matrix_stats_t;

    logic                      clk;
    logic                      rst_n;
    logic [15:0]               row_index;
    logic [15:0]               col_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      has_entry;
    logic                      row_last;
    logic                      matrix_last;
    logic                      entry_valid;
    logic                      entry_ready;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic [ABS_W-1:0]          min_abs_value;
    logic [ABS_W-1:0]          max_abs_value;
    logic [SQ_W-1:0]           sum_of_squares;
    logic [NZ_OUT_W-1:0]       min_row_nonzeros;
    logic [NZ_OUT_W-1:0]       max_row_nonzeros;
    logic [ROWS_OUT_W-1:0]     dominant_rows;
    logic [ROWS_OUT_W-1:0]     weak_dominant_rows;
    logic                      stats_valid;
    logic                      stats_ready;

    // Predicted statistics state.
    logic signed [VALUE_W-1:0] acc_min;
    logic signed [VALUE_W-1:0] acc_max;
    logic [ABS_W-1:0]          acc_min_abs;
    logic [ABS_W-1:0]          acc_max_abs;
    logic [SQ_W-1:0]           acc_squares;
    logic signed [VALUE_W-1:0] cur_diagonal;
    logic [OFF_W-1:0]          cur_offdiag;
    logic [NZ_OUT_W-1:0]       cur_count;
    logic [NZ_OUT_W-1:0]       acc_fewest;
    logic [NZ_OUT_W-1:0]       acc_most;
    logic [ROWS_OUT_W-1:0]     acc_strict;
    logic [ROWS_OUT_W-1:0]     acc_weak;

    matrix_stats_t expected_stats[$];
    matrix_stats_t oldest_stats;
    int            error_count;
    bit            idle_allowed;
    bit            entry_idle_on;
    bit            stats_stall_on;

    sparse_matrix_statistics_core DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .row_index          (row_index),
        .col_index          (col_index),
        .entry_value        (entry_value),
        .has_entry          (has_entry),
        .row_last           (row_last),
        .matrix_last        (matrix_last),
        .entry_valid        (entry_valid),
        .entry_ready        (entry_ready),
        .min_value          (min_value),
        .max_value          (max_value),
        .min_abs_value      (min_abs_value),
        .max_abs_value      (max_abs_value),
        .sum_of_squares     (sum_of_squares),
        .min_row_nonzeros   (min_row_nonzeros),
        .max_row_nonzeros   (max_row_nonzeros),
        .dominant_rows      (dominant_rows),
        .weak_dominant_rows (weak_dominant_rows),
        .stats_valid        (stats_valid),
        .stats_ready        (stats_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [MAG_W-1:0] magnitude_of(input logic signed [VALUE_W-1:0] v);
        begin
            magnitude_of = v[VALUE_W-1] ? ~v + 1 : v;
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        begin
            case ($urandom_range(0, 9))
                0: v = $urandom;
                1: v = VALUE_NEG_MAX;
                2: v = VALUE_POS_MAX;
                3: v = '0;
                4: v = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
                default:
                begin
                    v = $urandom_range(1, 1 << 20);
                    if ($urandom_range(0, 1))
                        v = -v;
                end
            endcase
            random_value = v;
        end
    endfunction

    task automatic clear_statistics();
        begin
            acc_min      = VALUE_POS_MAX;
            acc_max      = VALUE_NEG_MAX;
            acc_min_abs  = ABS_SAT;
            acc_max_abs  = '0;
            acc_squares  = '0;
            cur_diagonal = '0;
            cur_offdiag  = '0;
            cur_count    = '0;
            acc_fewest   = NZ_OUT_W'(MAX_ROW_ENTRIES);
            acc_most     = '0;
            acc_strict   = '0;
            acc_weak     = '0;
        end
    endtask

    task automatic predict_entry(input logic [15:0] row, input logic [15:0] col,
                                 input logic signed [VALUE_W-1:0] value,
                                 input logic has, input logic rlast, input logic mlast);
        logic [MAG_W-1:0] mag;
        logic [ABS_W-1:0] mag_sat;
        logic [63:0]      square;
        logic [63:0]      headroom;
        logic [OFF_W:0]   off_next;
        logic [OFF_W-1:0] diag_mag;
        matrix_stats_t    s;
        begin
            if (has)
            begin
                mag      = magnitude_of(value);
                mag_sat  = (mag > {1'b0, ABS_SAT}) ? ABS_SAT : mag[ABS_W-1:0];
                square   = 64'(mag) * 64'(mag);
                headroom = 64'(SQ_SAT) - 64'(acc_squares);
                if (value < acc_min)
                    acc_min = value;
                if (value > acc_max)
                    acc_max = value;
                if (mag_sat < acc_min_abs)
                    acc_min_abs = mag_sat;
                if (mag_sat > acc_max_abs)
                    acc_max_abs = mag_sat;
                acc_squares = (square > headroom) ? SQ_SAT : acc_squares + square[SQ_W-1:0];
                if (row == col)
                    cur_diagonal = value;
                else
                begin
                    off_next    = {1'b0, cur_offdiag} + (OFF_W+1)'(mag);
                    cur_offdiag = (off_next > {1'b0, OFF_SAT}) ? OFF_SAT : off_next[OFF_W-1:0];
                end
                if (cur_count < MAX_ROW_ENTRIES)
                    cur_count = cur_count + 1'b1;
            end

            // A matrix end closes the open row even without a row end.
            if (rlast || mlast)
            begin
                diag_mag = OFF_W'(magnitude_of(cur_diagonal));
                if (cur_count < acc_fewest)
                    acc_fewest = cur_count;
                if (cur_count > acc_most)
                    acc_most = cur_count;
                if (diag_mag > cur_offdiag)
                begin
                    if (acc_strict < MAX_ROWS)
                        acc_strict = acc_strict + 1'b1;
                end
                else if (diag_mag == cur_offdiag)
                begin
                    if (acc_weak < MAX_ROWS)
                        acc_weak = acc_weak + 1'b1;
                end
                cur_diagonal = '0;
                cur_offdiag  = '0;
                cur_count    = '0;
            end

            if (mlast)
            begin
                s.min_value          = acc_min;
                s.max_value          = acc_max;
                s.min_abs_value      = acc_min_abs;
                s.max_abs_value      = acc_max_abs;
                s.sum_of_squares     = acc_squares;
                s.min_row_nonzeros   = acc_fewest;
                s.max_row_nonzeros   = acc_most;
                s.dominant_rows      = acc_strict;
                s.weak_dominant_rows = acc_weak;
                expected_stats.push_back(s);
                clear_statistics();
            end
        end
    endtask

    // Sends one entry beat, with an optional idle burst first, and predicts it once taken.
    task automatic send_entry(input logic [15:0] row, input logic [15:0] col,
                              input logic signed [VALUE_W-1:0] value,
                              input logic has, input logic rlast, input logic mlast);
        begin
            if (entry_idle_on && $urandom_range(0, 3) == 0)
            begin
                entry_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            row_index   <= row;
            col_index   <= col;
            entry_value <= value;
            has_entry   <= has;
            row_last    <= rlast;
            matrix_last <= mlast;
            entry_valid <= 1'b1;
            @(posedge clk);
            while (!entry_ready)
                @(posedge clk);
            predict_entry(row, col, value, has, rlast, mlast);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            if (error_count < 100)
                $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
            error_count++;
        end
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        begin
            if (got !== want)
                report_mismatch(what, got, want);
        end
    endtask

    // Statistics beat checker.
    always @(posedge clk)
    begin
        if (rst_n && stats_valid && stats_ready)
        begin
            if (expected_stats.size() == 0)
                report_mismatch("unexpected statistics beat", '0, '0);
            else
            begin
                oldest_stats = expected_stats.pop_front();
                compare_field("min_value", min_value, oldest_stats.min_value);
                compare_field("max_value", max_value, oldest_stats.max_value);
                compare_field("min_abs_value", min_abs_value, oldest_stats.min_abs_value);
                compare_field("max_abs_value", max_abs_value, oldest_stats.max_abs_value);
                compare_field("sum_of_squares", sum_of_squares, oldest_stats.sum_of_squares);
                compare_field("min_row_nonzeros", min_row_nonzeros,
                              oldest_stats.min_row_nonzeros);
                compare_field("max_row_nonzeros", max_row_nonzeros,
                              oldest_stats.max_row_nonzeros);
                compare_field("dominant_rows", dominant_rows, oldest_stats.dominant_rows);
                compare_field("weak_dominant_rows", weak_dominant_rows,
                              oldest_stats.weak_dominant_rows);
            end
        end
    end

    // Receiver back-pressure.
    initial
    begin
        stats_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (stats_stall_on && $urandom_range(0, 2) == 0)
            begin
                stats_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            stats_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic test_empty_matrix();
        begin
            send_entry(16'h0000, 16'h0000, 32'sh0, 1'b0, 1'b0, 1'b1);
        end
    endtask

    // Extreme values, a repeated diagonal, an empty row, and a matrix end that also
    // closes its row. The full-scale entries of row 5 and the row 7 diagonals saturate the sum of squares.
    task automatic test_value_extremes();
        begin
            send_entry(16'd5, 16'd5, VALUE_POS_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'd5, 16'd9, VALUE_NEG_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'd5, 16'd1, 32'sh0, 1'b1, 1'b0, 1'b0);
            send_entry(16'd5, 16'd2, -32'sd1, 1'b1, 1'b1, 1'b0);
            send_entry(16'd7, 16'd7, Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd7, 16'd7, -Q_ONE, 1'b1, 1'b1, 1'b0);
            send_entry(16'd3, 16'hFFFF, 32'sh5A5A_A5A5, 1'b0, 1'b1, 1'b0);
            send_entry(16'hFFFF, 16'h0000, VALUE_NEG_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'hFFFF, 16'h0000, 32'sh1234_5678, 1'b1, 1'b0, 1'b0);
            send_entry(16'hFFFF, 16'hFFFF, -Q_ONE, 1'b1, 1'b0, 1'b1);
        end
    endtask

    // Strict, weak and failed dominance; the most negative diagonal uses its exact
    // magnitude against the off-diagonal sum.
    task automatic test_dominance();
        begin
            send_entry(16'd1, 16'd0, Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd1, 16'd1, 3 * Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd1, 16'd2, -Q_ONE, 1'b1, 1'b1, 1'b0);
            send_entry(16'd2, 16'd2, -2 * Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd2, 16'd0, Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd2, 16'd4, -Q_ONE, 1'b1, 1'b1, 1'b0);
            send_entry(16'd3, 16'd3, Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd3, 16'd1, 2 * Q_ONE, 1'b1, 1'b1, 1'b0);
            send_entry(16'd4, 16'd0, Q_ONE, 1'b1, 1'b0, 1'b0);
            send_entry(16'd4, 16'd0, 32'sh0, 1'b0, 1'b1, 1'b0);
            send_entry(16'd6, 16'd6, VALUE_NEG_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'd6, 16'd0, VALUE_POS_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'd6, 16'd1, 32'sd1, 1'b1, 1'b1, 1'b0);
            send_entry(16'd8, 16'd8, VALUE_NEG_MAX, 1'b1, 1'b0, 1'b0);
            send_entry(16'd8, 16'd0, VALUE_POS_MAX, 1'b1, 1'b0, 1'b1);
        end
    endtask

    // 512 full-scale off-diagonal entries reach exactly 2^40, so a wrapping sum would
    // look weakly dominant; the row count also saturates.
    task automatic test_long_row();
        begin
            for (int k = 0; k < 512; k++)
                send_entry(16'd40, 16'(k + 100), VALUE_NEG_MAX, 1'b1, k == 511, 1'b0);
            send_entry(16'd41, 16'd41, Q_ONE, 1'b1, 1'b0, 1'b1);
        end
    endtask

    task automatic test_random_matrices(input int item_goal);
        int                        sent;
        int                        n_rows;
        int                        n_off;
        int                        o_left;
        int                        d_left;
        int                        mode;
        bit                        last_row;
        bit                        broken;
        bit                        close_separate;
        bit                        final_item;
        logic [15:0]               row;
        logic signed [VALUE_W-1:0] off_vals [0:7];
        logic signed [VALUE_W-1:0] diag_val;
        logic signed [VALUE_W-1:0] v;
        logic [OFF_W:0]            off_total;
        logic [OFF_W:0]            diag_target;
        begin
            sent = 0;
            while (sent < item_goal)
            begin
                if (idle_allowed)
                begin
                    entry_idle_on  = $urandom_range(0, 3) != 0;
                    stats_stall_on = $urandom_range(0, 3) != 0;
                end
                n_rows = $urandom_range(1, 6);
                for (int r = 0; r < n_rows; r++)
                begin
                    last_row = (r == n_rows - 1);
                    broken   = last_row && $urandom_range(0, 2) == 0;
                    row      = 16'($urandom);
                    // Empty items that close nothing are ignored by the block.
                    if ($urandom_range(0, 19) == 0)
                        send_entry(16'($urandom), 16'($urandom), random_value(),
                                   1'b0, 1'b0, 1'b0);
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_entry(row, 16'($urandom), random_value(), 1'b0, !broken, last_row);
                        sent++;
                    end
                    else
                    begin
                        n_off     = $urandom_range(0, 5);
                        off_total = '0;
                        for (int k = 0; k < n_off; k++)
                        begin
                            off_vals[k] = random_value();
                            off_total   = off_total + (OFF_W+1)'(magnitude_of(off_vals[k]));
                        end
                        mode = $urandom_range(0, 4);
                        if (mode == 0 && n_off == 0)
                            mode = 1;
                        d_left = (mode == 0) ? 0 : (mode == 4) ? 2 : 1;
                        case (mode)
                            2: diag_target = off_total + (OFF_W+1)'($urandom_range(1, 255));
                            3: diag_target = (off_total > 0) ? off_total - 1'b1 : '0;
                            default: diag_target = off_total;
                        endcase
                        if (diag_target >= 41'h0_8000_0000)
                            diag_val = VALUE_NEG_MAX;
                        else
                        begin
                            diag_val = diag_target[VALUE_W-1:0];
                            if ($urandom_range(0, 1))
                                diag_val = -diag_val;
                        end
                        close_separate = $urandom_range(0, 3) == 0;
                        o_left = n_off;
                        while (d_left + o_left > 0)
                        begin
                            final_item = (d_left + o_left == 1) && !close_separate;
                            if ($urandom_range(1, d_left + o_left) <= d_left)
                            begin
                                // With two diagonals the first is a decoy the second replaces.
                                v = (d_left == 2) ? random_value() : diag_val;
                                d_left--;
                                send_entry(row, row, v, 1'b1, final_item && !broken,
                                           final_item && last_row);
                            end
                            else
                            begin
                                v = off_vals[n_off - o_left];
                                o_left--;
                                send_entry(row, row + 16'($urandom_range(1, 65535)), v, 1'b1,
                                           final_item && !broken, final_item && last_row);
                            end
                            sent++;
                        end
                        if (close_separate)
                        begin
                            send_entry(row, 16'($urandom), random_value(), 1'b0, !broken,
                                       last_row);
                            sent++;
                        end
                    end
                end
            end
        end
    endtask

    initial
    begin
        error_count    = 0;
        idle_allowed   = 1'b1;
        entry_idle_on  = 1'b1;
        stats_stall_on = 1'b1;
        clear_statistics();
        rst_n       <= 1'b0;
        row_index   <= '0;
        col_index   <= '0;
        entry_value <= '0;
        has_entry   <= 1'b0;
        row_last    <= 1'b0;
        matrix_last <= 1'b0;
        entry_valid <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_matrix();
        test_value_extremes();
        test_dominance();
        test_long_row();
        test_random_matrices(160);

        idle_allowed   = 1'b0;
        entry_idle_on  = 1'b0;
        stats_stall_on = 1'b0;
        test_random_matrices(50);

        entry_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
